// ===== sv/rsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsc_pkg
// shared types and constants of the ray sample compositor
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int PIX_BITS    = SAMPLE_BITS;
  localparam int MAX_DEPTH   = 1024;
  localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);
  localparam int Z_W         = 10;
  localparam int TRANS_W     = 16;
  localparam int VD_W        = 11;
  localparam int RUN_W       = 22;
  localparam int CNT_W       = 11;
  localparam int MODE_W      = 2;
  localparam int IDX_W       = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
  localparam logic [RUN_W-1:0]       RUN_LIMIT  = '1;
  localparam logic [CNT_W-1:0]       CNT_LIMIT  = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_MAX   = 2'd0,
    MODE_FIRST = 2'd1,
    MODE_AVG   = 2'd2,
    MODE_ALPHA = 2'd3
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE  = 2'd0,
    REG_TRANS = 2'd1,
    REG_DEPTH = 2'd2
  } reg_idx_t;

  localparam logic [TRANS_W-1:0] TRANS_RESET = 16'd13107;
  localparam logic [VD_W-1:0]    VD_RESET    = 11'd1024;

  // settings the front needs, depth already clamped
  typedef struct packed {
    mode_t                mode;
    logic [TRANS_W-1:0]   transparency;
    logic [DEPTH_W-1:0]   depth;
  } cfg_t;

  // state of one finished ray, handed from front to back
  typedef struct packed {
    mode_t                  mode;
    logic [RUN_W-1:0]       run_value;
    logic [CNT_W-1:0]       count;
    logic [SAMPLE_BITS-1:0] alpha;
  } ray_rec_t;

endpackage

// ===== sv/rsc_div.sv =====
// ----------------------------------------------------------------------------
// rsc_div
// restoring divider, one quotient bit per cycle, quotient known to fit Q_W bits
// ----------------------------------------------------------------------------
module rsc_div #(
  parameter int NUM_W = rsc_pkg::RUN_W,
  parameter int DEN_W = rsc_pkg::CNT_W,
  parameter int Q_W   = rsc_pkg::PIX_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [Q_W-1:0]   quot_o
);

  localparam int STEP_W = $clog2(Q_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DEN_W-1:0]  rem_r;
  logic [Q_W-1:0]    low_r;
  logic [DEN_W-1:0]  den_r;
  logic [Q_W-1:0]    quot_r;

  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  // remainder always stays below the divisor
  assign trial = {rem_r, low_r[Q_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i && !busy_r) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(Q_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i && !busy_r) begin
      rem_r <= DEN_W'(num_i >> Q_W);
      low_r <= num_i[Q_W-1:0];
      den_r <= den_i;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_r  <= {low_r[Q_W-2:0], 1'b0};
      quot_r <= {quot_r[Q_W-2:0], ge};
    end
  end

  assign done_o = done_r;
  assign quot_o = quot_r;

endmodule

// ===== sv/rsc_fifo.sv =====
// ----------------------------------------------------------------------------
// rsc_fifo
// short queue of finished ray records between front and back
// ----------------------------------------------------------------------------
module rsc_fifo #(
  parameter int DEPTH = rsc_pkg::QUEUE_DEPTH,
  parameter int WIDTH = $bits(rsc_pkg::ray_rec_t)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] fill_r;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (fill_r == CNT_W'(DEPTH));
  assign empty_o = (fill_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata_i;
    end
  end

endmodule

// ===== sv/rsc_front.sv =====
// ----------------------------------------------------------------------------
// rsc_front
// takes samples, accumulates per-ray state, hands finished rays to the queue
// ----------------------------------------------------------------------------
module rsc_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rsc_pkg::cfg_t                   cfg_i,
  input  logic                            in_push_i,
  output logic                            in_full_o,
  input  logic [rsc_pkg::SAMPLE_BITS-1:0] in_sample_i,
  input  logic [rsc_pkg::Z_W-1:0]         in_depth_pos_i,
  input  logic                            in_last_in_ray_i,
  output logic                            q_push_o,
  input  logic                            q_full_i,
  output rsc_pkg::ray_rec_t               q_rec_o
);

  localparam int PROD_W = rsc_pkg::SAMPLE_BITS + rsc_pkg::TRANS_W;
  localparam int MUL_W  = PROD_W + rsc_pkg::DEPTH_W;
  localparam int NUM_W  = MUL_W - rsc_pkg::TRANS_W;
  localparam int SB     = rsc_pkg::SAMPLE_BITS;
  localparam int RUN_W  = rsc_pkg::RUN_W;
  localparam int CNT_W  = rsc_pkg::CNT_W;
  localparam int DW     = rsc_pkg::DEPTH_W;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_DIV  = 3'b100
  } fstate_t;

  fstate_t           state_r, state_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SB-1:0]     alpha_r, alpha_nxt;
  logic              fin_r, fin_nxt;
  logic              last_r, last_nxt;

  logic [PROD_W-1:0] prod_r;
  logic [DW-1:0]     wgt_r;
  logic [DW-1:0]     dep_r;

  logic              accept;
  logic              z_inside;
  logic [DW-1:0]     wgt;
  logic [RUN_W:0]    sum;
  logic [MUL_W-1:0]  mul_full;
  logic [SB:0]       alpha_add;
  logic              div_start;
  logic              div_done;
  logic [SB-1:0]     quot;
  logic              ray_done;
  rsc_pkg::mode_t    rec_mode;
  rsc_pkg::ray_rec_t rec;

  assign in_full_o = (state_r != F_IDLE) || q_full_i;
  assign accept    = in_push_i && !in_full_o;

  // depth weight, zero for slices at or past the volume depth
  assign z_inside = (32'(in_depth_pos_i) < 32'(cfg_i.depth));
  assign wgt      = z_inside ? cfg_i.depth - DW'(in_depth_pos_i) : '0;
  assign sum      = {1'b0, run_r} + (RUN_W + 1)'(in_sample_i);
  assign mul_full = MUL_W'(prod_r) * MUL_W'(wgt_r);
  assign alpha_add = {1'b0, alpha_r} + {1'b0, quot};

  rsc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DW),
    .Q_W   (SB)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (mul_full[MUL_W-1:rsc_pkg::TRANS_W]),
    .den_i   (dep_r),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    state_nxt = state_r;
    run_nxt   = run_r;
    cnt_nxt   = cnt_r;
    alpha_nxt = alpha_r;
    fin_nxt   = fin_r;
    last_nxt  = last_r;
    div_start = 1'b0;
    ray_done  = 1'b0;
    rec_mode  = cfg_i.mode;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (!fin_r) begin
            case (cfg_i.mode)
              rsc_pkg::MODE_MAX: begin
                if (RUN_W'(in_sample_i) > run_r) begin
                  run_nxt = RUN_W'(in_sample_i);
                end
              end
              rsc_pkg::MODE_FIRST: begin
                if (in_sample_i != '0) begin
                  run_nxt = RUN_W'(in_sample_i);
                  fin_nxt = 1'b1;
                end
              end
              rsc_pkg::MODE_AVG: begin
                run_nxt = sum[RUN_W] ? rsc_pkg::RUN_LIMIT : sum[RUN_W-1:0];
                if (cnt_r != rsc_pkg::CNT_LIMIT) begin
                  cnt_nxt = cnt_r + 1'b1;
                end
              end
              default: ;
            endcase
          end
          if (fin_r || cfg_i.mode != rsc_pkg::MODE_ALPHA) begin
            ray_done = in_last_in_ray_i;
          end else begin
            state_nxt = F_MUL;
            last_nxt  = in_last_in_ray_i;
          end
        end
      end
      F_MUL: begin
        div_start = 1'b1;
        state_nxt = F_DIV;
      end
      F_DIV: begin
        rec_mode = rsc_pkg::MODE_ALPHA;
        if (div_done) begin
          if (alpha_add >= {1'b0, rsc_pkg::SAMPLE_MAX}) begin
            alpha_nxt = rsc_pkg::SAMPLE_MAX;
            fin_nxt   = 1'b1;
          end else begin
            alpha_nxt = alpha_add[SB-1:0];
          end
          ray_done  = last_r;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase

    rec = '{mode: rec_mode, run_value: run_nxt, count: cnt_nxt, alpha: alpha_nxt};

    // fresh ray after the record leaves
    if (ray_done) begin
      run_nxt   = '0;
      cnt_nxt   = '0;
      alpha_nxt = '0;
      fin_nxt   = 1'b0;
    end
  end

  assign q_push_o = ray_done;
  assign q_rec_o  = rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      run_r   <= '0;
      cnt_r   <= '0;
      alpha_r <= '0;
      fin_r   <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      run_r   <= run_nxt;
      cnt_r   <= cnt_nxt;
      alpha_r <= alpha_nxt;
      fin_r   <= fin_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r <= PROD_W'(in_sample_i) * PROD_W'(cfg_i.transparency);
      wgt_r  <= wgt;
      dep_r  <= cfg_i.depth;
    end
  end

  a_push_room : assert property (@(posedge clk) disable iff (!rst_n)
    q_push_o |-> !q_full_i)
    else $error("ray record pushed into a full queue");

  a_clear_after_ray : assert property (@(posedge clk) disable iff (!rst_n)
    q_push_o |=> (run_r == '0 && cnt_r == '0 && alpha_r == '0 && !fin_r))
    else $error("work state not cleared after a ray");

  a_done_in_div : assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == F_DIV))
    else $error("alpha divide finished outside the divide state");

endmodule

// ===== sv/rsc_back.sv =====
// ----------------------------------------------------------------------------
// rsc_back
// turns a finished ray record into a pixel, holds it for the result side
// ----------------------------------------------------------------------------
module rsc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty_i,
  input  rsc_pkg::ray_rec_t            q_rec_i,
  output logic                         q_pop_o,
  output logic                         out_empty_o,
  input  logic                         out_pop_i,
  output logic [rsc_pkg::PIX_BITS-1:0] out_pixel_o
);

  localparam int PB    = rsc_pkg::PIX_BITS;
  localparam int RUN_W = rsc_pkg::RUN_W;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_DIV  = 2'b10
  } bstate_t;

  bstate_t        state_r, state_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [PB-1:0]  pix_r, pix_nxt;

  logic           slot_free;
  logic           take;
  logic           need_div;
  logic           div_start;
  logic           div_done;
  logic [PB-1:0]  quot;
  logic [PB-1:0]  direct_pix;

  assign slot_free = !out_valid_r || out_pop_i;

  // every case except a real average division resolves at once
  always_comb begin
    need_div   = 1'b0;
    direct_pix = '0;
    case (q_rec_i.mode)
      rsc_pkg::MODE_MAX, rsc_pkg::MODE_FIRST: begin
        direct_pix = (q_rec_i.run_value > RUN_W'(rsc_pkg::SAMPLE_MAX)) ?
                     rsc_pkg::SAMPLE_MAX : q_rec_i.run_value[PB-1:0];
      end
      rsc_pkg::MODE_AVG: begin
        if (q_rec_i.count == '0) begin
          direct_pix = '0;
        end else if (32'(q_rec_i.run_value >> PB) >= 32'(q_rec_i.count)) begin
          direct_pix = rsc_pkg::SAMPLE_MAX;
        end else begin
          need_div = 1'b1;
        end
      end
      default: begin
        direct_pix = q_rec_i.alpha;
      end
    endcase
  end

  rsc_div #(
    .NUM_W (RUN_W),
    .DEN_W (rsc_pkg::CNT_W),
    .Q_W   (PB)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (q_rec_i.run_value),
    .den_i   (q_rec_i.count),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_pop_i;
    pix_nxt       = pix_r;
    take          = 1'b0;
    div_start     = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty_i && slot_free) begin
          take = 1'b1;
          if (need_div) begin
            div_start = 1'b1;
            state_nxt = B_DIV;
          end else begin
            pix_nxt       = direct_pix;
            out_valid_nxt = 1'b1;
          end
        end
      end
      B_DIV: begin
        if (div_done) begin
          pix_nxt       = quot;
          out_valid_nxt = 1'b1;
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  assign q_pop_o     = take;
  assign out_empty_o = !out_valid_r;
  assign out_pixel_o = pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

  a_slot_kept_free : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> !out_valid_r)
    else $error("output register busy while a division runs");

  a_done_in_div : assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == B_DIV))
    else $error("average divide finished outside the divide state");

endmodule

// ===== sv/ray_sample_compositor.sv =====
// ----------------------------------------------------------------------------
// ray_sample_compositor
// volume ray compositor: max intensity, first hit, average and alpha modes
// ----------------------------------------------------------------------------
// Samples of one ray go in on the in_ side in order, one pixel comes out on
// the out_ side for each sample flagged last_in_ray. The front takes a sample
// without leaving its idle state in maximum, first-hit and average mode, and
// in every mode once the ray has been stopped. An alpha sample that still
// counts goes through these steps: accept and form sample*transparency, the
// depth-weight multiply, the bit-serial divide by the volume depth and the
// fold of the result into the opacity sum, with in_full held high after the
// accept. Finished rays wait in a short record queue (QUEUE_DEPTH entries);
// the back turns each into a pixel at once, or through its divider for an
// average that really needs the divide, and holds it in an output register,
// so the front keeps taking samples while a pixel waits to be popped. in_full
// is also raised while the record queue is full. Configuration writes are
// always taken (cfg_ready is tied high) and are meant for times when no ray
// is in flight; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module ray_sample_compositor #(
  parameter int QUEUE_DEPTH = rsc_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // sample input, queue style
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [rsc_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic [rsc_pkg::Z_W-1:0]         in_depth_pos,
  input  logic                            in_last_in_ray,
  // pixel output, queue style
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [rsc_pkg::PIX_BITS-1:0]    out_pixel,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rsc_pkg::IDX_W-1:0]       cfg_index,
  input  logic [rsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int DW = rsc_pkg::DEPTH_W;

  // configuration registers
  rsc_pkg::mode_t               mode_r;
  logic [rsc_pkg::TRANS_W-1:0]  trans_r;
  logic [rsc_pkg::VD_W-1:0]     vdepth_r;

  logic [DW-1:0]                depth_eff;
  rsc_pkg::cfg_t                cfg;

  logic                         q_push;
  logic                         q_full;
  logic                         q_pop;
  logic                         q_empty;
  rsc_pkg::ray_rec_t            q_wrec;
  rsc_pkg::ray_rec_t            q_rrec;
  logic [$bits(rsc_pkg::ray_rec_t)-1:0] q_rdata;

  assign cfg_ready = 1'b1;

  // register write transfer; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= rsc_pkg::MODE_ALPHA;
      trans_r  <= rsc_pkg::TRANS_RESET;
      vdepth_r <= rsc_pkg::VD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rsc_pkg::reg_idx_t'(cfg_index))
        rsc_pkg::REG_MODE:  mode_r   <= rsc_pkg::mode_t'(cfg_data[rsc_pkg::MODE_W-1:0]);
        rsc_pkg::REG_TRANS: trans_r  <= cfg_data[rsc_pkg::TRANS_W-1:0];
        rsc_pkg::REG_DEPTH: vdepth_r <= cfg_data[rsc_pkg::VD_W-1:0];
        default: ;
      endcase
    end
  end

  // depth clamped to 1..MAX_DEPTH
  always_comb begin
    if (vdepth_r == '0) begin
      depth_eff = DW'(1);
    end else if (32'(vdepth_r) > 32'(rsc_pkg::MAX_DEPTH)) begin
      depth_eff = DW'(rsc_pkg::MAX_DEPTH);
    end else begin
      depth_eff = DW'(vdepth_r);
    end
  end

  assign cfg = '{mode: mode_r, transparency: trans_r, depth: depth_eff};

  // front: per-sample accumulation
  rsc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_i            (cfg),
    .in_push_i        (in_push),
    .in_full_o        (in_full),
    .in_sample_i      (in_sample),
    .in_depth_pos_i   (in_depth_pos),
    .in_last_in_ray_i (in_last_in_ray),
    .q_push_o         (q_push),
    .q_full_i         (q_full),
    .q_rec_o          (q_wrec)
  );

  // queue of finished rays, decouples the two sides
  rsc_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(rsc_pkg::ray_rec_t))
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .wdata_i (q_wrec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  assign q_rrec = rsc_pkg::ray_rec_t'(q_rdata);

  // back: pixel forming and result register
  rsc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty_i   (q_empty),
    .q_rec_i     (q_rrec),
    .q_pop_o     (q_pop),
    .out_empty_o (out_empty),
    .out_pop_i   (out_pop),
    .out_pixel_o (out_pixel)
  );

endmodule
